// ===== rtl/tpid_pkg.sv =====
// Package for the two-port integrator debounce: widths, codes, state enum
// and the command/status structs between controller and datapath.
// No dependencies.
package tpid_pkg;

  localparam int DEF_PINS_PER_PORT = 8;
  localparam int FIELD_W           = 8;   // pin and state field width
  localparam int CNT_W             = 8;   // signed integrator width
  localparam int FLOOR_W           = 8;
  localparam int CEIL_W            = 7;
  localparam int CFG_DATA_W        = 8;
  localparam int CFG_IDX_W         = 1;

  localparam logic [FLOOR_W-1:0]  FLOOR_RESET     = 8'sd0;
  localparam logic [CEIL_W-1:0]   CEIL_RESET      = 7'd5;
  localparam logic [FIELD_W-1:0]  BTN_FORCED_MASK = 8'h01;  // button pin 0 reads high

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOOR   = 1'b0,
    REG_CEILING = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_BTN  = 2'd1,
    SRC_ENC  = 2'd2
  } src_t;

  typedef enum logic {
    PORT_BTN = 1'b0,
    PORT_ENC = 1'b1
  } port_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BTN_CHK,
    ST_BTN_SCAN,
    ST_ENC_CHK,
    ST_ENC_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic  load_in;   // capture pins of the accepted item
    logic  clr_idx;   // restart pin scan at pin 0
    logic  step;      // integrate one pin of the selected port
    port_t port;
    logic  out_load;  // move debounced state into the output register
    src_t  src;
  } tpid_cmd_t;

  typedef struct packed {
    logic btn_mismatch;
    logic enc_mismatch;
    logic changed;    // pin under scan flips its debounced bit
    logic last_pin;
    logic out_busy;   // output register full and not taken this cycle
  } tpid_sts_t;

endpackage

// ===== rtl/two_port_integrator_debounce.sv =====
// Top level of the two-port integrator debounce.
// Depends on tpid_pkg, tpid_ctrl and tpid_datapath.
//
// Usage:
//   One input item is one debounce tick: the raw active-low button and
//   encoder port levels. Button pin 0 always reads as released. Each item
//   yields exactly one result: the debounced button and encoder bits after
//   the tick and which port changed (none, buttons, encoder). Both channels
//   are valid/ready; an item moves when valid and ready are both high at a
//   rising edge. The user must write limits on the cfg port (index 0 floor,
//   signed; index 1 ceiling) only while no tick is in flight; not enforced.
// Timing:
//   The controller scans one pin per cycle, button port first, then the
//   encoder port. A port whose bits already match its pins is skipped.
//   A new item is accepted only after the previous result is loaded into
//   the output register. The scan runs through the single integrator step.
// Reset (synchronous, active low) clears all integrators and debounced
// bits and loads floor 0, ceiling 5. A stalled receiver keeps the result
// in the output register; the next item can still be accepted and is held
// at its final step until the output register frees up.
module two_port_integrator_debounce import tpid_pkg::*; #(
  parameter int PINS_PER_PORT = DEF_PINS_PER_PORT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FIELD_W-1:0]    in_button_pins,
  input  logic [FIELD_W-1:0]    in_encoder_pins,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FIELD_W-1:0]    out_button_state,
  output logic [FIELD_W-1:0]    out_encoder_state,
  output logic [1:0]            out_change_source,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tpid_cmd_t cmd;
  tpid_sts_t sts;

  // sequencing: port checks, pin scan, hand-off to output register
  tpid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // integrators, debounced bits, limits and the result register
  tpid_datapath #(
    .PINS_PER_PORT (PINS_PER_PORT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_button_pins    (in_button_pins),
    .in_encoder_pins   (in_encoder_pins),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_button_state  (out_button_state),
    .out_encoder_state (out_encoder_state),
    .out_change_source (out_change_source)
  );

endmodule

// ===== rtl/tpid_datapath.sv =====
// Datapath of the two-port integrator debounce: config registers, pin
// capture, per-pin integrators, debounced bits and the output register.
// Depends on tpid_pkg.
module tpid_datapath import tpid_pkg::*; #(
  parameter int PINS_PER_PORT = DEF_PINS_PER_PORT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [FIELD_W-1:0]    in_button_pins,
  input  logic [FIELD_W-1:0]    in_encoder_pins,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  tpid_cmd_t             cmd_i,
  output tpid_sts_t             sts_o,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [FIELD_W-1:0]    out_button_state,
  output logic [FIELD_W-1:0]    out_encoder_state,
  output logic [1:0]            out_change_source
);

  localparam int IDX_W = (PINS_PER_PORT > 1) ? $clog2(PINS_PER_PORT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PINS_PER_PORT - 1);

  logic signed [FLOOR_W-1:0]     floor_r;
  logic        [CEIL_W-1:0]      ceil_r;
  logic [PINS_PER_PORT-1:0]      btn_pins_r, enc_pins_r;
  logic [PINS_PER_PORT-1:0]      btn_pins_in, enc_pins_in;
  logic [CNT_W-1:0]              btn_cnt_r [PINS_PER_PORT];
  logic [CNT_W-1:0]              enc_cnt_r [PINS_PER_PORT];
  logic [CNT_W-1:0]              btn_cnt_nxt [PINS_PER_PORT];
  logic [CNT_W-1:0]              enc_cnt_nxt [PINS_PER_PORT];
  logic [PINS_PER_PORT-1:0]      btn_bits_r, enc_bits_r, btn_bits_nxt, enc_bits_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]            out_btn_r, out_enc_r, btn_bits8, enc_bits8;
  logic [1:0]                    out_src_r;

  // current pin
  logic                          pin;
  logic                          cur_bit, new_bit;
  logic [CNT_W-1:0]              cur_cnt, new_cnt;
  logic signed [CNT_W:0]         up_val, dn_val, floor_ext, ceil_ext;
  logic                          up_hit, dn_hit;

  // Map the 8-bit fields onto the scanned pins; missing pins read low.
  always_comb begin
    for (int i = 0; i < PINS_PER_PORT; i++) begin
      if (i < FIELD_W) begin
        btn_pins_in[i] = in_button_pins[i % FIELD_W];
        enc_pins_in[i] = in_encoder_pins[i % FIELD_W];
      end else begin
        btn_pins_in[i] = 1'b0;
        enc_pins_in[i] = 1'b0;
      end
    end
    btn_pins_in[0] = btn_pins_in[0] | BTN_FORCED_MASK[0];
  end

  always_comb begin
    for (int j = 0; j < FIELD_W; j++) begin
      if (j < PINS_PER_PORT) begin
        btn_bits8[j] = btn_bits_r[j % PINS_PER_PORT];
        enc_bits8[j] = enc_bits_r[j % PINS_PER_PORT];
      end else begin
        btn_bits8[j] = 1'b0;
        enc_bits8[j] = 1'b0;
      end
    end
  end

  // Integrator step for the selected pin.
  always_comb begin
    if (cmd_i.port == PORT_ENC) begin
      pin     = enc_pins_r[idx_r];
      cur_bit = enc_bits_r[idx_r];
      cur_cnt = enc_cnt_r[idx_r];
    end else begin
      pin     = btn_pins_r[idx_r];
      cur_bit = btn_bits_r[idx_r];
      cur_cnt = btn_cnt_r[idx_r];
    end
    up_val    = $signed({cur_cnt[CNT_W-1], cur_cnt}) + (CNT_W+1)'(1);
    dn_val    = $signed({cur_cnt[CNT_W-1], cur_cnt}) - (CNT_W+1)'(1);
    floor_ext = $signed({floor_r[FLOOR_W-1], floor_r});
    ceil_ext  = $signed({2'b00, ceil_r});
    dn_hit    = dn_val < floor_ext;
    // encoder asserts strictly above the ceiling, buttons at it
    up_hit    = (cmd_i.port == PORT_ENC) ? (up_val > ceil_ext) : (up_val >= ceil_ext);
    if (pin) begin
      new_cnt = dn_hit ? floor_r : dn_val[CNT_W-1:0];
      new_bit = dn_hit ? 1'b0 : cur_bit;
    end else begin
      new_cnt = up_hit ? {1'b0, ceil_r} : up_val[CNT_W-1:0];
      new_bit = up_hit ? 1'b1 : cur_bit;
    end
  end

  always_comb begin
    btn_cnt_nxt  = btn_cnt_r;
    enc_cnt_nxt  = enc_cnt_r;
    btn_bits_nxt = btn_bits_r;
    enc_bits_nxt = enc_bits_r;
    idx_nxt      = idx_r;
    if (cmd_i.clr_idx) begin
      idx_nxt = '0;
    end else if (cmd_i.step) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (cmd_i.step) begin
      if (cmd_i.port == PORT_ENC) begin
        enc_cnt_nxt[idx_r]  = new_cnt;
        enc_bits_nxt[idx_r] = new_bit;
      end else begin
        btn_cnt_nxt[idx_r]  = new_cnt;
        btn_bits_nxt[idx_r] = new_bit;
      end
    end
    out_valid_nxt = out_valid_r;
    if (cmd_i.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r     <= FLOOR_RESET;
      ceil_r      <= CEIL_RESET;
      btn_bits_r  <= '0;
      enc_bits_r  <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < PINS_PER_PORT; k++) begin
        btn_cnt_r[k] <= '0;
        enc_cnt_r[k] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_FLOOR:   floor_r <= cfg_data[FLOOR_W-1:0];
          REG_CEILING: ceil_r  <= cfg_data[CEIL_W-1:0];
          default:     ;
        endcase
      end
      btn_bits_r  <= btn_bits_nxt;
      enc_bits_r  <= enc_bits_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      btn_cnt_r   <= btn_cnt_nxt;
      enc_cnt_r   <= enc_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_in) begin
      btn_pins_r <= btn_pins_in;
      enc_pins_r <= enc_pins_in;
    end
    if (cmd_i.out_load) begin
      out_btn_r <= btn_bits8;
      out_enc_r <= enc_bits8;
      out_src_r <= cmd_i.src;
    end
  end

  assign sts_o.btn_mismatch = |(btn_bits_r ^ ~btn_pins_r);
  assign sts_o.enc_mismatch = |(enc_bits_r ^ ~enc_pins_r);
  assign sts_o.changed      = new_bit != cur_bit;
  assign sts_o.last_pin     = idx_r == LAST_IDX;
  assign sts_o.out_busy     = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_button_state  = out_btn_r;
  assign out_encoder_state = out_enc_r;
  assign out_change_source = out_src_r;

  // at most one debounced bit moves per scan step
  a_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.step |=> ($countones({btn_bits_r, enc_bits_r} ^
                               $past({btn_bits_r, enc_bits_r})) <= 1))
    else $error("more than one debounced bit changed in a step");

  a_bits_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_i.step |=> ($stable(btn_bits_r) && $stable(enc_bits_r)))
    else $error("debounced bits changed outside a scan step");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.out_load |=> (out_valid_r && out_src_r == $past(cmd_i.src)))
    else $error("output register not loaded");

endmodule

// ===== rtl/tpid_ctrl.sv =====
// Controller of the two-port integrator debounce: sequences the port
// checks and the pin-by-pin scan, and hands the result to the output stage.
// Depends on tpid_pkg.
module tpid_ctrl import tpid_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tpid_sts_t sts_i,
  output tpid_cmd_t cmd_o
);

  state_t state_r, state_nxt;
  src_t   src_r, src_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    src_nxt   = src_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_BTN_CHK;
        end
      end
      ST_BTN_CHK: begin
        state_nxt = sts_i.btn_mismatch ? ST_BTN_SCAN : ST_ENC_CHK;
      end
      ST_BTN_SCAN: begin
        if (sts_i.changed) begin
          src_nxt   = SRC_BTN;
          state_nxt = ST_FINISH;
        end else if (sts_i.last_pin) begin
          state_nxt = ST_ENC_CHK;
        end
      end
      ST_ENC_CHK: begin
        if (sts_i.enc_mismatch) begin
          state_nxt = ST_ENC_SCAN;
        end else begin
          src_nxt   = SRC_NONE;
          state_nxt = ST_FINISH;
        end
      end
      ST_ENC_SCAN: begin
        if (sts_i.changed) begin
          src_nxt   = SRC_ENC;
          state_nxt = ST_FINISH;
        end else if (sts_i.last_pin) begin
          src_nxt   = SRC_NONE;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd_o.load_in = 1'b0;
    cmd_o.clr_idx = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.port    = PORT_BTN;
    cmd_o.out_load = 1'b0;
    cmd_o.src     = src_r;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd_o.load_in = in_valid;
        cmd_o.clr_idx = 1'b1;
      end
      ST_BTN_CHK: begin
        cmd_o.clr_idx = 1'b1;
      end
      ST_BTN_SCAN: begin
        cmd_o.step    = 1'b1;
        cmd_o.clr_idx = sts_i.last_pin;
      end
      ST_ENC_CHK: begin
        cmd_o.clr_idx = 1'b1;
        cmd_o.port    = PORT_ENC;
      end
      ST_ENC_SCAN: begin
        cmd_o.step = 1'b1;
        cmd_o.port = PORT_ENC;
      end
      ST_FINISH: begin
        cmd_o.out_load = !sts_i.out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      src_r   <= SRC_NONE;
    end else begin
      state_r <= state_nxt;
      src_r   <= src_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_BTN_CHK))
    else $error("accepted item did not start the button check");

  a_change_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.step && sts_i.changed) |=>
      (state_r == ST_FINISH && src_r != SRC_NONE))
    else $error("state change did not end the tick");

  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && sts_i.out_busy) |=>
      (state_r == ST_FINISH && $stable(src_r)))
    else $error("result dropped while output stage was full");

endmodule

// ===== bench/tb.sv =====
// Testbench for two_port_integrator_debounce: random and directed debounce ticks,
// checked item by item against a behavioral predictor kept in this file.
// Depends on tpid_pkg and the RTL of two_port_integrator_debounce.
module tb;
  import tpid_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PINS         = DEF_PINS_PER_PORT;
  localparam int DRAIN_CYCLES = 2 * (2 * PINS + 4);  // drain wait, longer than the longest tick
  localparam int STALL_LIMIT  = 2000;                // cycles with no handshake or register write

  // One predicted result item.
  typedef struct {
    logic [FIELD_W-1:0] btn;
    logic [FIELD_W-1:0] enc;
    src_t               src;
  } debounce_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Inputs start at known values; after that only the driver, monitor and
  // config task move them, always at a rising edge.
  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  logic [FIELD_W-1:0]    in_button_pins    = '1;
  logic [FIELD_W-1:0]    in_encoder_pins   = '1;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  logic [FIELD_W-1:0]    out_button_state;
  logic [FIELD_W-1:0]    out_encoder_state;
  logic [1:0]            out_change_source;
  logic                  cfg_write_en      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index         = REG_FLOOR;
  logic [CFG_DATA_W-1:0] cfg_data          = '0;

  // Ticks waiting to be offered: {button pins, encoder pins}.
  logic [2*FIELD_W-1:0]  tick_queue[$];
  debounce_result_t      results_due[$];
  debounce_result_t      oldest_due;

  int ticks_queued       = 0;
  int ticks_taken        = 0;
  int error_count        = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles       = 0;

  // Predictor state: one integrator per pin, debounced bits, and the limits.
  int                 integ[2][PINS];
  logic [FIELD_W-1:0] db_bits[2];
  int                 trip_floor;
  int                 trip_ceiling;

  two_port_integrator_debounce DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_button_pins    (in_button_pins),
    .in_encoder_pins   (in_encoder_pins),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_button_state  (out_button_state),
    .out_encoder_state (out_encoder_state),
    .out_change_source (out_change_source),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Integrate one port, pin 0 first. Returns 1 as soon as a debounced bit
  // flips; the pins after it keep their counters for this tick.
  // Buttons assert at >= ceiling, encoder lines only strictly above it.
  function automatic bit scan_port(port_t p, logic [FIELD_W-1:0] pins);
    logic [FIELD_W-1:0] was;
    int v;
    int i;
    was = db_bits[p];
    // Skip the port when its bits already agree with the inverted pins.
    if ((db_bits[p] ^ ~pins) == '0) return 1'b0;
    for (i = 0; i < PINS; i++) begin
      if (pins[i]) begin
        v = integ[p][i] - 1;
        if (v < trip_floor) begin
          db_bits[p][i] = 1'b0;
          v = trip_floor;
        end
      end else begin
        v = integ[p][i] + 1;
        if ((p == PORT_ENC) ? (v > trip_ceiling) : (v >= trip_ceiling)) begin
          db_bits[p][i] = 1'b1;
          v = trip_ceiling;
        end
      end
      integ[p][i] = v;
      if (db_bits[p] != was) return 1'b1;
    end
    return 1'b0;
  endfunction

  // One accepted tick: the encoder port is looked at only when no button
  // bit changed.
  function automatic void debounce_tick(logic [FIELD_W-1:0] bp, logic [FIELD_W-1:0] ep);
    debounce_result_t r;
    src_t s;
    s = SRC_NONE;
    if (scan_port(PORT_BTN, bp | BTN_FORCED_MASK)) s = SRC_BTN;
    else if (scan_port(PORT_ENC, ep)) s = SRC_ENC;
    r.btn = db_bits[PORT_BTN];
    r.enc = db_bits[PORT_ENC];
    r.src = s;
    results_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers queued ticks, with random idle cycles. Prediction runs
  // on the edge where a tick is taken.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        debounce_tick(in_button_pins, in_encoder_pins);
        ticks_taken++;
      end
      // Slot is free when nothing is offered or the offer was just taken.
      if (!in_valid || in_ready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          {in_button_pins, in_encoder_pins} <= tick_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, compares every taken result with the
  // oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result btn=%h enc=%h src=%0d", $time,
                   out_button_state, out_encoder_state, out_change_source);
          error_count++;
        end else begin
          oldest_due = results_due.pop_front();
          if (out_button_state !== oldest_due.btn) begin
            $display("%0t: button_state expected %h got %h", $time,
                     oldest_due.btn, out_button_state);
            error_count++;
          end
          if (out_encoder_state !== oldest_due.enc) begin
            $display("%0t: encoder_state expected %h got %h", $time,
                     oldest_due.enc, out_encoder_state);
            error_count++;
          end
          if (out_change_source !== oldest_due.src) begin
            $display("%0t: change_source expected %0d got %0d", $time,
                     oldest_due.src, out_change_source);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void push_tick(logic [FIELD_W-1:0] bp, logic [FIELD_W-1:0] ep);
    tick_queue.push_back({bp, ep});
    ticks_queued++;
  endfunction

  // Wait until every queued tick is taken and its result has come back.
  task automatic wait_drained();
    while (ticks_taken != ticks_queued || results_due.size() != 0) @(posedge clk);
  endtask

  // Both limits in back-to-back writes; only called with nothing in flight.
  task automatic write_limits(int fl, int ce);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_FLOOR;
    cfg_data     <= fl[7:0];
    @(posedge clk);
    cfg_index    <= REG_CEILING;
    cfg_data     <= {1'b0, ce[6:0]};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    trip_floor   = fl;
    trip_ceiling = ce;
  endtask

  // A switch event: a few bouncy ticks around a target pattern, then the
  // target held long enough (usually) to cross a limit. Now and then a lone
  // noise tick instead.
  task automatic queue_pattern();
    logic [FIELD_W-1:0] bp, ep;
    int span, hold, k;
    bp = 8'($urandom);
    ep = 8'($urandom);
    if ($urandom_range(9) == 0) begin
      push_tick(bp, ep);
      return;
    end
    span = (trip_ceiling > -trip_floor) ? trip_ceiling : -trip_floor;
    repeat ($urandom_range(0, 3)) begin
      push_tick(bp ^ 8'($urandom), ep ^ 8'($urandom));
    end
    // Long holds are rare so wide limits don't eat the whole budget.
    k = (span > 12) ? 12 : span;
    if ($urandom_range(3) == 0) hold = $urandom_range(1, span + 3);
    else hold = $urandom_range(1, k + 3);
    repeat (hold) push_tick(bp, ep);
  endtask

  task automatic run_phase(int fl, int ce, int s_idle, int r_stall, int n_items);
    int stop_at;
    wait_drained();
    write_limits(fl, ce);
    sender_idle_pct    = s_idle;
    receiver_stall_pct = r_stall;
    stop_at = ticks_queued + n_items;
    while (ticks_queued < stop_at) queue_pattern();
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    foreach (integ[p, i]) integ[p][i] = 0;
    db_bits[PORT_BTN] = '0;
    db_bits[PORT_ENC] = '0;
    trip_floor   = int'($signed(FLOOR_RESET));
    trip_ceiling = int'(CEIL_RESET);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks at the reset limits (floor 0, ceiling 5).
    push_tick(8'hFF, 8'hFF);                 // all released: both ports skipped
    repeat (12) push_tick(8'h00, 8'h00);     // encoder scanned only in ticks where no button bit flips
    repeat (7) push_tick(8'hFF, 8'h00);      // buttons release, encoder gets its turn
    repeat (4) push_tick(8'hFE, 8'hFF);      // pin 0 low but forced high
    push_tick(8'h55, 8'hAA);

    // No idling. The second call of the same setting makes the sender hold
    // off until every result of the first half is back.
    run_phase(0, 3, 0, 0, 100);
    run_phase(0, 3, 0, 0, 100);
    run_phase(-2, 6, 65, 0, 200);
    // Deepest floor: counters sink to -127 ahead of the next, tighter floor.
    run_phase(-127, 0, 0, 65, 150);
    // Highest ceiling: counters climb toward 126 before the ceiling drops to 1.
    run_phase(-5, 126, 35, 35, 150);
    run_phase(-1, 1, 35, 35, 50);
    run_phase(0, 0, 35, 35, 50);

    wait_drained();
    receiver_stall_pct = 0;
    // Anything the block emits from here on has no prediction.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, results_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== two_port_integrator_debounce.f =====
rtl/tpid_pkg.sv
rtl/tpid_datapath.sv
rtl/tpid_ctrl.sv
rtl/two_port_integrator_debounce.sv
bench/tb.sv
